>>> hdl/assert_macros.svh
// Assertion macros used by the checker, hie_checker.sv.
// Each macro expects a signal named clk, and all but HIE_ASSERT_RST also rst_n, in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define HIE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hilbert encoder check failed (same cycle)");

// Next-cycle implication, off while reset is asserted.
`define HIE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hilbert encoder check failed (next cycle)");

// Next-cycle implication that stays active through reset.
`define HIE_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("hilbert encoder check failed (reset)");

`endif

>>> hdl/hie_pkg.sv
// Types, constants and the walk step function of the 2D Hilbert index encoder.
// No dependencies; used by the top level and the checker.
`timescale 1ns / 1ps

package hie_pkg;

  localparam int LEVELS    = 31;
  localparam int GRID_W    = 31;
  localparam int COORD_W   = 32;
  localparam int TAG_W     = 32;
  localparam int CODE_W    = 2 * GRID_W;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int FRAC_W    = 16;
  localparam int LVL_PER_STG = 4;
  localparam int HIL_STG   = (LEVELS + LVL_PER_STG - 1) / LVL_PER_STG;
  localparam int FRONT_STG = 3;
  localparam int NUM_STG   = FRONT_STG + HIL_STG;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y   = 2'd3;

  localparam logic [COORD_W-1:0] SCALE_RST = 32'h0001_0000;
  localparam logic [GRID_W-1:0]  GRID_MAX  = {GRID_W{1'b1}};

  typedef logic [1:0]        sym_t;
  typedef sym_t [3:0]        rot_t;
  typedef logic [GRID_W-1:0] grid_t;
  typedef logic [CODE_W-1:0] code_t;

  typedef struct packed {
    rot_t  rot;
    code_t code;
  } hil_t;

  localparam rot_t START_ROT = {2'd3, 2'd0, 2'd2, 2'd1};
  localparam rot_t NEXT_ROT [4] = '{
    {2'd1, 2'd2, 2'd3, 2'd0},
    {2'd3, 2'd2, 2'd1, 2'd0},
    {2'd3, 2'd2, 2'd1, 2'd0},
    {2'd3, 2'd0, 2'd1, 2'd2}
  };

  // gx and gy arrive with the next level's bit at the top.
  function automatic hil_t hil_step(input rot_t rot_in, input code_t code_in,
                                    input grid_t gx, input grid_t gy, input int base);
    hil_t res;
    rot_t nrot;
    sym_t word;
    sym_t sym;
    res.rot  = rot_in;
    res.code = code_in;
    for (int j = 0; j < LVL_PER_STG; j++) begin
      if (base + j < LEVELS) begin
        word = {gy[GRID_W-1-j], gx[GRID_W-1-j]};
        sym  = res.rot[word];
        for (int k = 0; k < 4; k++) begin
          nrot[k] = NEXT_ROT[sym][res.rot[k]];
        end
        res.rot  = nrot;
        res.code = {res.code[CODE_W-3:0], sym};
      end
    end
    return res;
  endfunction

endpackage

>>> hdl/hilbert_index_2d_encoder_unit.sv
// 2D Hilbert index encoder: grid mapping front end and pipelined Hilbert walk.
// Depends on hie_pkg.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid / in_stall) takes one request per cycle while
//   in_stall is low: signed Q16.16 x and y coordinates and a 32-bit point index.
//   Output channel (out_valid / out_stall) gives the 62-bit Hilbert code and
//   the point index as tag, in request order.
//   Configuration: cfg_we writes cfg_wdata to the register at cfg_index
//   (0 box_min_x, 1 box_min_y, 2 scale_x, 3 scale_y). Write only while idle.
//   Pipeline: eleven register stages from acceptance to out_valid: offset,
//   multiply, clamp, then eight walk stages of four levels (three in the last).
//   Throughput: one request per cycle while in_stall is low, with a registered
//   32x32 multiplier and four walk levels per stage.
//   Reset (rst_n low, synchronous) empties the pipeline and restores
//   box minima to 0 and scales to 1.0.
//   When the receiver stalls, the output holds; upstream stages keep
//   filling empty slots, and in_stall rises only once every stage is full.
module hilbert_index_2d_encoder_unit import hie_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [COORD_W-1:0] in_x_coord,
  input  logic signed [COORD_W-1:0] in_y_coord,
  input  logic [TAG_W-1:0]      in_point_index,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CODE_W-1:0]     out_hilbert_code,
  output logic [TAG_W-1:0]      out_point_tag,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_W-1:0]    cfg_wdata
);

  logic [COORD_W-1:0] box_min_x_r, box_min_y_r, scale_x_r, scale_y_r;

  logic [NUM_STG-1:0] vld_r;
  logic [NUM_STG-1:0] en;
  logic [TAG_W-1:0]   tag_r [NUM_STG];

  logic [COORD_W:0]   dx_nxt, dy_nxt;
  logic [COORD_W-1:0] mx_r, my_r;
  logic [PROD_W-1:0]  px_r, py_r;
  grid_t              gx_r, gy_r;

  grid_t hgx_r   [HIL_STG];
  grid_t hgy_r   [HIL_STG];
  rot_t  hrot_r  [HIL_STG];
  code_t hcode_r [HIL_STG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_min_x_r <= '0;
      box_min_y_r <= '0;
      scale_x_r   <= SCALE_RST;
      scale_y_r   <= SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BOX_MIN_X: box_min_x_r <= cfg_wdata;
        REG_BOX_MIN_Y: box_min_y_r <= cfg_wdata;
        REG_SCALE_X:   scale_x_r   <= cfg_wdata;
        REG_SCALE_Y:   scale_y_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // advance a stage when it is empty or its successor advances
  assign en[NUM_STG-1] = !vld_r[NUM_STG-1] || !out_stall;
  for (genvar k = 0; k < NUM_STG - 1; k++) begin : g_en
    assign en[k] = !vld_r[k] || en[k+1];
  end

  assign in_stall = !en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STG; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      tag_r[0] <= in_point_index;
    end
    for (int k = 1; k < NUM_STG; k++) begin
      if (en[k]) begin
        tag_r[k] <= tag_r[k-1];
      end
    end
  end

  // offset: drop non-positive differences to zero
  assign dx_nxt = {in_x_coord[COORD_W-1], in_x_coord} - {box_min_x_r[COORD_W-1], box_min_x_r};
  assign dy_nxt = {in_y_coord[COORD_W-1], in_y_coord} - {box_min_y_r[COORD_W-1], box_min_y_r};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mx_r <= dx_nxt[COORD_W] ? '0 : dx_nxt[COORD_W-1:0];
      my_r <= dy_nxt[COORD_W] ? '0 : dy_nxt[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      px_r <= PROD_W'(mx_r) * PROD_W'(scale_x_r);
      py_r <= PROD_W'(my_r) * PROD_W'(scale_y_r);
    end
  end

  // clamp the shifted product to the grid range
  always_ff @(posedge clk) begin
    if (en[2]) begin
      gx_r <= (|px_r[PROD_W-1:FRAC_W+GRID_W]) ? GRID_MAX : px_r[FRAC_W+GRID_W-1:FRAC_W];
      gy_r <= (|py_r[PROD_W-1:FRAC_W+GRID_W]) ? GRID_MAX : py_r[FRAC_W+GRID_W-1:FRAC_W];
    end
  end

  for (genvar h = 0; h < HIL_STG; h++) begin : g_hil
    grid_t src_gx, src_gy;
    rot_t  src_rot;
    code_t src_code;
    hil_t  step;

    if (h == 0) begin : g_first
      assign src_gx   = gx_r;
      assign src_gy   = gy_r;
      assign src_rot  = START_ROT;
      assign src_code = '0;
    end else begin : g_next
      assign src_gx   = hgx_r[h-1];
      assign src_gy   = hgy_r[h-1];
      assign src_rot  = hrot_r[h-1];
      assign src_code = hcode_r[h-1];
    end

    assign step = hil_step(src_rot, src_code, src_gx, src_gy, h * LVL_PER_STG);

    always_ff @(posedge clk) begin
      if (en[FRONT_STG+h]) begin
        hgx_r[h]   <= src_gx << LVL_PER_STG;
        hgy_r[h]   <= src_gy << LVL_PER_STG;
        hrot_r[h]  <= step.rot;
        hcode_r[h] <= step.code;
      end
    end
  end

  assign out_valid        = vld_r[NUM_STG-1];
  assign out_hilbert_code = hcode_r[HIL_STG-1];
  assign out_point_tag    = tag_r[NUM_STG-1];

endmodule

>>> hdl/hie_checker.sv
// Port-level checker for the 2D Hilbert index encoder, bound to the top level.
// Depends on hie_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hie_checker import hie_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [CODE_W-1:0] out_hilbert_code,
  input logic [TAG_W-1:0]  out_point_tag
);

  `HIE_ASSERT_RST(a_rst_empty, !rst_n, !out_valid)
  `HIE_ASSERT_IMP(a_stall_full, in_stall, out_valid && out_stall)
  `HIE_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
  `HIE_ASSERT_NXT(a_out_stable, out_valid && out_stall,
                  $stable(out_hilbert_code) && $stable(out_point_tag))

endmodule

bind hilbert_index_2d_encoder_unit hie_checker u_hie_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_hilbert_code (out_hilbert_code),
  .out_point_tag    (out_point_tag)
);
